FILE: src/film_grain_pixel_core_defines.svh
// ----------------------------------------------------------------------------
// film_grain_pixel_core_defines.svh
// Assertion macros shared by the film grain pixel core.
// ----------------------------------------------------------------------------
`ifndef FILM_GRAIN_PIXEL_CORE_DEFINES_SVH
`define FILM_GRAIN_PIXEL_CORE_DEFINES_SVH

// Antecedent true implies the consequent, checked on the same clock edge.
// The consequent may be a sequence, for instance one that opens with a delay.
`define FGP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// Antecedent true implies the consequent on the following clock edge.
`define FGP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error(msg);

`endif

FILE: src/fgp_pkg.sv
// ----------------------------------------------------------------------------
// fgp_pkg
// Types and fixed constants of the film grain pixel core.
// ----------------------------------------------------------------------------
package fgp_pkg;

  // One input word: three Q4.12 channels and the pixel coordinates.
  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
  } fgp_pixel_in_t;

  // One result word: the grained channels.
  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
  } fgp_pixel_out_t;

  // Noise magnitude and sign handed from a hash lane to the core.
  typedef struct packed {
    logic        neg;
    logic [23:0] mag;
  } fgp_noise_t;

  // Configuration register indexes.
  localparam logic CfgIdxAmount = 1'b0;
  localparam logic CfgIdxSeed   = 1'b1;

  // Hash multipliers.
  localparam logic [31:0] HashMulX   = 32'd374761393;
  localparam logic [31:0] HashMulY   = 32'd668265263;
  localparam logic [31:0] HashMulMix = 32'd1274126177;

  // Rec.709 luma weights in Q0.16; they sum to 1.0.
  localparam logic [15:0] LumaCoefR = 16'd13933;
  localparam logic [15:0] LumaCoefG = 16'd46871;
  localparam logic [15:0] LumaCoefB = 16'd4732;

  // Mid-grey, 0.05 in Q0.16, and the smallest grain amount that is applied.
  localparam logic [15:0] MidGrey     = 16'd2048;
  localparam logic [11:0] FivePctQ16  = 12'd3277;
  localparam logic [15:0] BypassLimit = 16'd66;

  localparam logic [23:0] NoiseFull = 24'hFFFFFF;

endpackage

FILE: src/fgp_noise.sv
// ----------------------------------------------------------------------------
// fgp_noise
// One lane of the per-pixel noise hash, two register stages deep.
// ----------------------------------------------------------------------------
module fgp_noise
  import fgp_pkg::*;
(
  input  logic        clk_i,
  input  logic [31:0] seed_i,
  input  logic [1:0]  chan_i,
  input  logic [31:0] xy_i,
  output fgp_noise_t  noise_o
);

  logic [31:0] h_seed;
  logic [31:0] h_mix;
  logic [31:0] hm_d, hm_q;
  logic [31:0] h_fin;
  logic [23:0] n24;
  logic [24:0] twice_n;
  fgp_noise_t  noise_d, noise_q;

  // Seed offset by the channel number, mixed with the coordinate products.
  assign h_seed = (seed_i + 32'(chan_i)) ^ xy_i;
  assign h_mix  = h_seed ^ (h_seed >> 13);
  assign hm_d   = h_mix * HashMulMix;

  always_ff @(posedge clk_i) begin
    hm_q <= hm_d;
  end

  // The noise is 2n - (2^24 - 1), odd and therefore never zero.
  assign h_fin   = hm_q ^ (hm_q >> 16);
  assign n24     = h_fin[23:0];
  assign twice_n = {n24, 1'b0};

  always_comb begin
    noise_d.neg = ~n24[23];
    if (n24[23]) begin
      noise_d.mag = 24'(twice_n - {1'b0, NoiseFull});
    end else begin
      noise_d.mag = 24'({1'b0, NoiseFull} - twice_n);
    end
  end

  always_ff @(posedge clk_i) begin
    noise_q <= noise_d;
  end

  assign noise_o = noise_q;

endmodule

FILE: src/film_grain_pixel_core.sv
// ----------------------------------------------------------------------------
// film_grain_pixel_core
// Additive hash-noise film grain on one RGB pixel a clock.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Handshake
//  --------  --------------------------------------  ----------------------------
//  pixel in  start_i, busy_o, pixel_i                 word taken when start_i & !busy_o
//  result    done_o, result_o                         word valid for the one cycle of done_o
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i         register written when cfg_we_i
//
// A new pixel word may be started in every cycle, so the sustained rate is one
// word a clock. The datapath has seven stages: luma and the coordinate
// products, the grey distance, its square, the amount product, the
// five-percent scaling, the noise product and the final add and clamp.
// busy_o is never raised and the result side cannot stall, so the pipeline
// simply advances every cycle. Reset clears the valid bits and the two
// configuration registers; the datapath registers are not reset.
//
// Each channel draws its own noise from a 32-bit multiply and xor hash of the
// seed plus the channel number and of the two coordinates. The noise is
// scaled by the grain amount times 0.05 times a luminance weight that grows
// with the distance of the pixel's luma from mid-grey, so mid-tones receive
// the least grain. Grain amounts below 66 pass the pixel through untouched.
// ----------------------------------------------------------------------------
`include "film_grain_pixel_core_defines.svh"

module film_grain_pixel_core
  import fgp_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  fgp_pixel_in_t  pixel_i,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [31:0]    cfg_wdata_i,
  output logic           done_o,
  output fgp_pixel_out_t result_o
);

  localparam int unsigned PipeDepth = 7;

  typedef logic [2:0][15:0] chan_set_t;

  // Configuration registers.
  logic [15:0] amount_q;
  logic [31:0] seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amount_q <= '0;
      seed_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxAmount: amount_q <= cfg_wdata_i[15:0];
        CfgIdxSeed:   seed_q   <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // The result side cannot push back, so a word is always taken.
  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Valid bits, one for each stage.
  logic [PipeDepth-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[PipeDepth-2:0], accept};
    end
  end

  // The channels travel alongside the arithmetic to the final add.
  chan_set_t pix_q [PipeDepth-1];
  chan_set_t pix_in;

  assign pix_in = {pixel_i.blue_in, pixel_i.green_in, pixel_i.red_in};

  always_ff @(posedge clk_i) begin
    pix_q[0] <= pix_in;
    for (int i = 1; i < PipeDepth - 1; i++) begin
      pix_q[i] <= pix_q[i-1];
    end
  end

  // Stage 1: luma in Q4.12 and the shared coordinate part of the hash.
  logic [31:0] luma_sum;
  logic [15:0] luma_q;
  logic [31:0] xy_d, xy_q;

  assign luma_sum = 32'(pixel_i.red_in)   * 32'(LumaCoefR)
                  + 32'(pixel_i.green_in) * 32'(LumaCoefG)
                  + 32'(pixel_i.blue_in)  * 32'(LumaCoefB)
                  + 32'd32768;
  assign xy_d = (32'(pixel_i.pixel_x) * HashMulX) ^ (32'(pixel_i.pixel_y) * HashMulY);

  always_ff @(posedge clk_i) begin
    luma_q <= luma_sum[31:16];
    xy_q   <= xy_d;
  end

  // Stage 2: doubled distance from mid-grey, no clamp above 1.0.
  logic [16:0] d_d, d_q;

  always_comb begin
    if (luma_q >= MidGrey) begin
      d_d = {luma_q - MidGrey, 1'b0};
    end else begin
      d_d = {MidGrey - luma_q, 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
  end

  // Stage 3: weight w = 0.5 + 0.5 * d^2 in Q.12.
  logic [33:0] d_sq;
  logic [20:0] w_q;

  assign d_sq = 34'(d_q) * 34'(d_q);

  always_ff @(posedge clk_i) begin
    w_q <= 21'((d_sq + 34'd4096) >> 13) + 21'd2048;
  end

  // Three noise lanes: hash mixing in stage 2, noise magnitude in stage 3.
  fgp_noise_t noise3 [3];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    fgp_noise u_noise (
      .clk_i   (clk_i),
      .seed_i  (seed_q),
      .chan_i  (2'(c)),
      .xy_i    (xy_q),
      .noise_o (noise3[c])
    );
  end

  // Stage 4: grain amount times weight.
  logic [36:0] aw_q;
  fgp_noise_t  noise4_q [3];

  always_ff @(posedge clk_i) begin
    aw_q <= 37'(amount_q) * 37'(w_q);
    for (int c = 0; c < 3; c++) begin
      noise4_q[c] <= noise3[c];
    end
  end

  // Stage 5: scale by 0.05 and round to the Q.24 gain s.
  logic [48:0] s_full;
  logic [28:0] s_q;
  fgp_noise_t  noise5_q [3];

  assign s_full = 49'(aw_q) * 49'(FivePctQ16) + 49'h80000;

  always_ff @(posedge clk_i) begin
    s_q <= s_full[48:20];
    for (int c = 0; c < 3; c++) begin
      noise5_q[c] <= noise4_q[c];
    end
  end

  // Stage 6: gain times noise magnitude, one product a channel.
  logic [52:0] prod_q [3];
  logic [2:0]  neg6_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      prod_q[c] <= 53'(s_q) * 53'(noise5_q[c].mag);
      neg6_q[c] <= noise5_q[c].neg;
    end
  end

  // Stage 7: round the offset half away from zero, apply it and clamp.
  function automatic logic [15:0] apply_grain(logic [15:0] ch, logic [52:0] prod,
                                              logic neg);
    logic [53:0] rnd;
    logic [17:0] dmag;
    logic [18:0] res;
    rnd  = 54'(prod) + (54'd1 << 35);
    dmag = rnd[53:36];
    if (neg) begin
      res = {3'b000, ch} - {1'b0, dmag};
      return res[18] ? 16'd0 : res[15:0];
    end else begin
      res = {3'b000, ch} + {1'b0, dmag};
      return (res[18:16] != 3'b000) ? 16'hFFFF : res[15:0];
    end
  endfunction

  chan_set_t out_d;
  chan_set_t out_q;
  logic      bypass;

  assign bypass = amount_q < BypassLimit;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (bypass) begin
        out_d[c] = pix_q[PipeDepth-2][c];
      end else begin
        out_d[c] = apply_grain(pix_q[PipeDepth-2][c], prod_q[c], neg6_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o             = valid_q[PipeDepth-1];
  assign result_o.red_out   = out_q[0];
  assign result_o.green_out = out_q[1];
  assign result_o.blue_out  = out_q[2];

  // Every accepted word leaves with a done_o strobe, and no strobe appears
  // without a word behind it.
  `FGP_ASSERT_IMPLIES(a_word_leaves, accept, ##PipeDepth done_o, "accepted word did not leave")
  `FGP_ASSERT_IMPLIES(a_no_stray_done, done_o, $past(accept, PipeDepth), "result without a word")
  // Under bypass the result equals the pixel that entered.
  `FGP_ASSERT_IMPLIES(a_bypass_exact, done_o && bypass, (result_o.red_out == $past(pixel_i.red_in, PipeDepth) && result_o.green_out == $past(pixel_i.green_in, PipeDepth) && result_o.blue_out == $past(pixel_i.blue_in, PipeDepth)), "bypass result differs from input")

endmodule
